// ===== src/power_quality_evaluator_assert.svh =====
// Assertion macros shared by the evaluator RTL.
// Each macro checks a property on the rising edge of clk, off during reset.
`ifndef POWER_QUALITY_EVALUATOR_ASSERT_SVH
`define POWER_QUALITY_EVALUATOR_ASSERT_SVH
`ifndef SYNTH
`define PQE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("power quality evaluator check failed");
`define PQE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("power quality evaluator check failed");
`else
`define PQE_ASSERT_IMP(lbl, ante, cons)
`define PQE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/pqe_pkg.sv =====
`default_nettype none
package pqe_pkg;

	localparam int PW      = 24;         // power magnitude width
	localparam int RADW    = 2 * PW;     // width of P^2 + Q^2
	localparam int REMW    = PW + 2;     // square root remainder width
	localparam int QW      = 11;         // quotient and power factor width
	localparam int NUMW    = PW + 10;    // width of |P| * 1000
	localparam int FLAGW   = 7;
	localparam int GRADEW  = 3;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_VOLT_NOM = 2'd0,
		REG_CURR_NOM = 2'd1,
		REG_PF_MIN   = 2'd2,
		REG_THD_MAX  = 2'd3
	} reg_idx_t;

	// Safety flag bit positions.
	localparam int FLAG_OV   = 0;
	localparam int FLAG_UV   = 1;
	localparam int FLAG_OC   = 2;
	localparam int FLAG_PF   = 4;
	localparam int FLAG_THD  = 5;
	localparam int FLAG_FREQ = 6;

	// Fixed thresholds of the grade penalties and frequency flag.
	localparam logic [11:0] THD_PEN1   = 12'd30;
	localparam logic [11:0] THD_PEN2   = 12'd50;
	localparam logic [15:0] FREQ_LOW   = 16'd4800;
	localparam logic [15:0] FREQ_HIGH  = 16'd5200;
	localparam logic [15:0] FREQ_LO1   = 16'd4950;
	localparam logic [15:0] FREQ_HI1   = 16'd5050;
	localparam logic [15:0] FREQ_LO2   = 16'd4900;
	localparam logic [15:0] FREQ_HI2   = 16'd5100;
	localparam logic signed [QW-1:0] PF_PEN1 = 11'sd950;
	localparam logic signed [QW-1:0] PF_PEN2 = 11'sd850;
	localparam logic signed [QW-1:0] PF_UNITY = 11'sd1000;
	localparam logic [GRADEW-1:0] GRADE_MAX = 3'd5;

	// Per-item data that rides along the arithmetic pipelines.
	typedef struct packed {
		logic              neg;
		logic [PW-1:0]     pm;
		logic [FLAGW-1:0]  flags;
		logic [GRADEW-1:0] grade;
	} side_t;

endpackage
`default_nettype wire

// ===== src/pqe_sqrt.sv =====
`default_nettype none
module pqe_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [pqe_pkg::RADW-1:0]    in_rad,
	input  wire pqe_pkg::side_t              in_side,
	output logic                             out_valid,
	output logic [pqe_pkg::PW-1:0]           out_root,
	output pqe_pkg::side_t                   out_side
);
	localparam int N = pqe_pkg::PW;

	logic [N-1:0]                  vld_s;
	logic [pqe_pkg::REMW-1:0]      rem_s  [N];
	logic [pqe_pkg::PW-1:0]        root_s [N];
	logic [pqe_pkg::RADW-1:0]      rad_s  [N];
	pqe_pkg::side_t                side_s [N];

	logic [pqe_pkg::REMW-1:0]      rem_d  [N];
	logic [pqe_pkg::PW-1:0]        root_d [N];
	logic [pqe_pkg::RADW-1:0]      rad_d  [N];

	// One result bit per stage: bring down two radicand bits, try the subtract.
	always_comb begin
		logic [pqe_pkg::REMW-1:0] rem_in;
		logic [pqe_pkg::PW-1:0]   root_in;
		logic [pqe_pkg::RADW-1:0] rad_in;
		logic [pqe_pkg::REMW-1:0] rem_t;
		logic [pqe_pkg::REMW-1:0] trial;
		for (int k = 0; k < N; k++) begin
			rem_in  = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k - 1];
			root_in = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k - 1];
			rad_in  = (k == 0) ? in_rad : rad_s[(k == 0) ? 0 : k - 1];
			rem_t   = {rem_in[pqe_pkg::REMW-3:0], rad_in[pqe_pkg::RADW-1 -: 2]};
			trial   = {root_in, 2'b01};
			rad_d[k] = {rad_in[pqe_pkg::RADW-3:0], 2'b00};
			if (rem_t >= trial) begin
				rem_d[k]  = rem_t - trial;
				root_d[k] = {root_in[pqe_pkg::PW-2:0], 1'b1};
			end else begin
				rem_d[k]  = rem_t;
				root_d[k] = {root_in[pqe_pkg::PW-2:0], 1'b0};
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_d[k];
				root_s[k] <= root_d[k];
				rad_s[k]  <= rad_d[k];
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];
endmodule
`default_nettype wire

// ===== src/pqe_div.sv =====
`default_nettype none
module pqe_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [pqe_pkg::NUMW-1:0]    in_num,
	input  wire logic [pqe_pkg::PW-1:0]      in_den,
	input  wire pqe_pkg::side_t              in_side,
	output logic                             out_valid,
	output logic [pqe_pkg::QW-1:0]           out_quot,
	output logic [pqe_pkg::PW-1:0]           out_den,
	output pqe_pkg::side_t                   out_side
);
	localparam int N  = pqe_pkg::QW;
	localparam int TW = pqe_pkg::PW + pqe_pkg::QW;

	logic [N-1:0]                  vld_s;
	logic [pqe_pkg::NUMW-1:0]      rem_s  [N];
	logic [pqe_pkg::QW-1:0]        quot_s [N];
	logic [pqe_pkg::PW-1:0]        den_s  [N];
	pqe_pkg::side_t                side_s [N];

	logic [pqe_pkg::NUMW-1:0]      rem_d  [N];
	logic [pqe_pkg::QW-1:0]        quot_d [N];

	// Restoring division, quotient bit N-1-k decided in stage k.
	always_comb begin
		logic [pqe_pkg::NUMW-1:0] rem_in;
		logic [pqe_pkg::QW-1:0]   quot_in;
		logic [pqe_pkg::PW-1:0]   den_in;
		logic [TW-1:0]            shd;
		for (int k = 0; k < N; k++) begin
			rem_in  = (k == 0) ? in_num : rem_s[(k == 0) ? 0 : k - 1];
			quot_in = (k == 0) ? '0 : quot_s[(k == 0) ? 0 : k - 1];
			den_in  = (k == 0) ? in_den : den_s[(k == 0) ? 0 : k - 1];
			shd     = {{pqe_pkg::QW{1'b0}}, den_in} << (N - 1 - k);
			if ({{(TW - pqe_pkg::NUMW){1'b0}}, rem_in} >= shd) begin
				rem_d[k]  = rem_in - shd[pqe_pkg::NUMW-1:0];
				quot_d[k] = {quot_in[pqe_pkg::QW-2:0], 1'b1};
			end else begin
				rem_d[k]  = rem_in;
				quot_d[k] = {quot_in[pqe_pkg::QW-2:0], 1'b0};
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_d[k];
				quot_s[k] <= quot_d[k];
				den_s[k]  <= (k == 0) ? in_den : den_s[(k == 0) ? 0 : k - 1];
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_quot  = quot_s[N-1];
	assign out_den   = den_s[N-1];
	assign out_side  = side_s[N-1];
endmodule
`default_nettype wire

// ===== src/power_quality_evaluator.sv =====
// Channel  | Direction | Payload
// s_axis   | in        | one measurement set per request
// m_axis   | out       | apparent power, power factor, flags, grade
// cfg      | in        | register index and write data
//
// One measurement set is accepted every cycle while the output is not stalled; the result
// passes 40 register stages before it is presented on m_axis.
// The depth is set by the 24-stage square root and the 11-stage divider.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; s_tready follows the output side.
`default_nettype none
module power_quality_evaluator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// volts_rms[15:0], amps_rms[31:16], real_power[55:32], imag_power[79:56],
	// volt_distortion[91:80], amp_distortion[103:92], line_freq[119:104]
	input  wire logic [119:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// apparent_power[23:0], pf_value[34:24], alarm_flags[41:35],
	// supply_grade[44:42], zero pad
	output logic [47:0]       m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);
	logic [13:0] volt_nom_q;
	logic [15:0] curr_nom_q;
	logic [9:0]  pf_min_q;
	logic [11:0] thd_max_q;

	logic en;
	logic out_valid_q;

	logic [15:0] volts, amps, freq;
	logic signed [23:0] rp, ip;
	logic [11:0] vthd, athd;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [pqe_pkg::PW-1:0]   qm_s1;
	pqe_pkg::side_t           side_s1, side_s2, side_s3, side_s4;
	logic [pqe_pkg::RADW-1:0] psq_s2, qsq_s2, rad_s3;
	logic [pqe_pkg::NUMW-1:0] num_s4;
	logic [pqe_pkg::PW-1:0]   root_s4;

	logic                     sq_valid;
	logic [pqe_pkg::PW-1:0]   sq_root;
	pqe_pkg::side_t           sq_side;
	logic                     dv_valid;
	logic [pqe_pkg::QW-1:0]   dv_quot;
	logic [pqe_pkg::PW-1:0]   dv_den;
	pqe_pkg::side_t           dv_side;

	logic [pqe_pkg::PW-1:0]     s_out_q;
	logic signed [pqe_pkg::QW-1:0] pf_out_q;
	logic [pqe_pkg::FLAGW-1:0]  flags_out_q;
	logic [pqe_pkg::GRADEW-1:0] grade_out_q;

	logic signed [pqe_pkg::QW-1:0] pf_fin;
	logic [pqe_pkg::FLAGW-1:0]     flags_fin;
	logic [pqe_pkg::GRADEW:0]      grade_sum;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_nom_q <= 14'd2500;
			curr_nom_q <= 16'd10000;
			pf_min_q   <= 10'd850;
			thd_max_q  <= 12'd50;
		end else if (cfg_we) begin
			case (pqe_pkg::reg_idx_t'(cfg_index))
				pqe_pkg::REG_VOLT_NOM: volt_nom_q <= cfg_data[13:0];
				pqe_pkg::REG_CURR_NOM: curr_nom_q <= cfg_data;
				pqe_pkg::REG_PF_MIN:   pf_min_q   <= cfg_data[9:0];
				pqe_pkg::REG_THD_MAX:  thd_max_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a result waits on a stalled output.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	assign volts = s_tdata[15:0];
	assign amps  = s_tdata[31:16];
	assign rp    = s_tdata[55:32];
	assign ip    = s_tdata[79:56];
	assign vthd  = s_tdata[91:80];
	assign athd  = s_tdata[103:92];
	assign freq  = s_tdata[119:104];

	// Stage 1: magnitudes, threshold flags and the penalties that do not need pf.
	always_ff @(posedge clk) begin
		logic [pqe_pkg::FLAGW-1:0]  fl;
		logic [pqe_pkg::GRADEW-1:0] gr;
		if (en) begin
			fl = '0;
			fl[pqe_pkg::FLAG_OV] = ({5'b0, volts} * 21'd10) > ({7'b0, volt_nom_q} * 21'd11);
			fl[pqe_pkg::FLAG_UV] = ({7'b0, volts} * 23'd100) < ({9'b0, volt_nom_q} * 23'd85);
			fl[pqe_pkg::FLAG_OC] = ({4'b0, amps} * 20'd10) > ({4'b0, curr_nom_q} * 20'd9);
			fl[pqe_pkg::FLAG_THD] = (vthd > thd_max_q) || (athd > thd_max_q);
			fl[pqe_pkg::FLAG_FREQ] = (freq < pqe_pkg::FREQ_LOW) || (freq > pqe_pkg::FREQ_HIGH);
			gr = 3'(vthd > pqe_pkg::THD_PEN1 || athd > pqe_pkg::THD_PEN1)
				+ 3'(vthd > pqe_pkg::THD_PEN2 || athd > pqe_pkg::THD_PEN2)
				+ 3'(freq < pqe_pkg::FREQ_LO1 || freq > pqe_pkg::FREQ_HI1)
				+ 3'(freq < pqe_pkg::FREQ_LO2 || freq > pqe_pkg::FREQ_HI2);
			side_s1.neg   <= rp[23];
			side_s1.pm    <= rp[23] ? 24'(-rp) : rp;
			side_s1.flags <= fl;
			side_s1.grade <= gr;
			qm_s1         <= ip[23] ? 24'(-ip) : ip;
		end
	end

	// Stage 2: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			psq_s2  <= {24'b0, side_s1.pm} * {24'b0, side_s1.pm};
			qsq_s2  <= {24'b0, qm_s1} * {24'b0, qm_s1};
			side_s2 <= side_s1;
		end
	end

	// Stage 3: sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= psq_s2 + qsq_s2;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
		end
	end

	pqe_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    (rad_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Stage 4: scale |P| by 1000 for the power factor quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= {10'b0, sq_side.pm} * 34'd1000;
			root_s4 <= sq_root;
			side_s4 <= sq_side;
		end
	end

	pqe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (num_s4),
		.in_den    (root_s4),
		.in_side   (side_s4),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_den   (dv_den),
		.out_side  (dv_side)
	);

	// Final stage: sign the power factor (unity when S is zero), add its flag and penalties, saturate.
	always_comb begin
		if (dv_den == '0) begin
			pf_fin = pqe_pkg::PF_UNITY;
		end else if (dv_side.neg) begin
			pf_fin = -$signed(dv_quot);
		end else begin
			pf_fin = $signed(dv_quot);
		end
		flags_fin = dv_side.flags;
		flags_fin[pqe_pkg::FLAG_PF] = pf_fin < $signed({1'b0, pf_min_q});
		grade_sum = {1'b0, dv_side.grade}
			+ 4'(pf_fin < pqe_pkg::PF_PEN1) + 4'(pf_fin < pqe_pkg::PF_PEN2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_out_q     <= dv_den;
			pf_out_q    <= pf_fin;
			flags_out_q <= flags_fin;
			grade_out_q <= (grade_sum > {1'b0, pqe_pkg::GRADE_MAX}) ?
				pqe_pkg::GRADE_MAX : grade_sum[pqe_pkg::GRADEW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b0, grade_out_q, flags_out_q, pf_out_q, s_out_q};

`include "power_quality_evaluator_assert.svh"

	`PQE_ASSERT_IMP(a_grade_range, m_tvalid, m_tdata[44:42] <= 3'd5)
	`PQE_ASSERT_IMP(a_zero_s_unity_pf, m_tvalid && m_tdata[23:0] == 24'd0, m_tdata[34:24] == 11'd1000)
	`PQE_ASSERT_IMP(a_no_overpower, m_tvalid, m_tdata[38] == 1'b0)
	`PQE_ASSERT_IMP(a_ready_when_empty, !out_valid_q, s_tready)
endmodule
`default_nettype wire
